@@ rtl/efr_pkg.sv @@
`timescale 1ns / 1ps

package efr_pkg;

  localparam int EFR_HEADER_BYTES = 4;
  localparam int EFR_MAX_PAYLOAD  = 56;
  localparam int EFR_BUFFER_LIMIT = 63;

  localparam int PTR_W       = 6;
  localparam int STORE_DEPTH = 1 << PTR_W;

  localparam logic [1:0] CFG_ESCAPE  = 2'd0;
  localparam logic [1:0] CFG_START   = 2'd1;
  localparam logic [1:0] CFG_END     = 2'd2;
  localparam logic [1:0] CFG_CHANNEL = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic [7:0] escape_byte;
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [2:0] channel_id;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

endpackage

@@ rtl/efr_store.sv @@
`timescale 1ns / 1ps

module efr_store (
  input  logic                    clk,
  input  efr_pkg::wr_req_t        wr,
  input  logic [efr_pkg::PTR_W-1:0] rd_addr,
  output logic [7:0]              rd_data
);
  import efr_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/efr_ctrl.sv @@
`timescale 1ns / 1ps

module efr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  efr_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_frame_byte,
  output logic [5:0]                out_byte_index,
  output logic                      out_last,
  output logic [5:0]                out_payload_length,
  output logic [15:0]               out_checksum,
  output logic [1:0]                out_status,
  output efr_pkg::wr_req_t          wr,
  output logic [efr_pkg::PTR_W-1:0] rd_addr,
  input  logic [7:0]                rd_data
);
  import efr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLO, S_CHI, S_CHK, S_FETCH, S_LOAD, S_OUT
  } state_t;

  localparam logic [PTR_W-1:0] HDR2 = PTR_W'(EFR_HEADER_BYTES + 2);
  localparam logic [PTR_W-1:0] TWO  = PTR_W'(2);

  state_t           state_r, state_nxt;
  logic             esc_r, esc_nxt;
  logic [PTR_W-1:0] fp_r, fp_nxt;
  logic [PTR_W-1:0] n_r, n_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [5:0]       bidx_r, bidx_nxt;
  logic             last_r, last_nxt;
  logic [5:0]       plen_r, plen_nxt;
  logic [15:0]      csum_r, csum_nxt;
  logic [1:0]       status_r, status_nxt;

  logic             take;
  logic             is_store;
  logic [PTR_W-1:0] plen_w;
  logic [PTR_W-1:0] body_w;

  assign take   = in_valid && in_ready;
  assign is_store = esc_r || (in_rx_byte != cfg.escape_byte &&
                              in_rx_byte != cfg.start_byte &&
                              in_rx_byte != cfg.end_byte);
  assign plen_w = n_r - HDR2;
  assign body_w = n_r - TWO;

  always_comb begin
    state_nxt  = state_r;
    esc_nxt    = esc_r;
    fp_nxt     = fp_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    lo_nxt     = lo_r;
    byte_nxt   = byte_r;
    bidx_nxt   = bidx_r;
    last_nxt   = last_r;
    plen_nxt   = plen_r;
    csum_nxt   = csum_r;
    status_nxt = status_r;
    wr.en      = 1'b0;
    wr.addr    = fp_r;
    wr.data    = in_rx_byte;
    rd_addr    = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (is_store) begin
            esc_nxt = 1'b0;
            wr.en   = 1'b1;
            if (int'(fp_r) < EFR_BUFFER_LIMIT) begin
              fp_nxt = fp_r + 1'b1;
            end
          end else if (in_rx_byte == cfg.escape_byte) begin
            esc_nxt = 1'b1;
          end else if (in_rx_byte == cfg.start_byte) begin
            fp_nxt = '0;
          end else begin
            n_nxt     = fp_r;
            state_nxt = S_CLO;
          end
        end
      end
      S_CLO: begin
        rd_addr   = n_r - TWO;
        state_nxt = S_CHI;
      end
      S_CHI: begin
        rd_addr   = n_r - 1'b1;
        lo_nxt    = rd_data;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        csum_nxt = (n_r >= TWO) ? {rd_data, lo_r} : 16'd0;
        byte_nxt = '0;
        bidx_nxt = '0;
        last_nxt = 1'b1;
        plen_nxt = '0;
        idx_nxt  = '0;
        if (int'(n_r) < EFR_HEADER_BYTES + 2) begin
          status_nxt = ST_TOO_SHORT;
          state_nxt  = S_OUT;
        end else if (int'(plen_w) > EFR_MAX_PAYLOAD) begin
          status_nxt = ST_TOO_LONG;
          state_nxt  = S_OUT;
        end else begin
          status_nxt = ST_OK;
          plen_nxt   = plen_w;
          state_nxt  = (body_w == '0) ? S_OUT : S_FETCH;
        end
      end
      S_FETCH: begin
        rd_addr   = idx_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        byte_nxt  = rd_data;
        bidx_nxt  = idx_r;
        last_nxt  = (idx_r + 1'b1 == body_w);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      esc_r   <= 1'b0;
      fp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      fp_r    <= fp_nxt;
    end
    n_r      <= n_nxt;
    idx_r    <= idx_nxt;
    lo_r     <= lo_nxt;
    byte_r   <= byte_nxt;
    bidx_r   <= bidx_nxt;
    last_r   <= last_nxt;
    plen_r   <= plen_nxt;
    csum_r   <= csum_nxt;
    status_r <= status_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_frame_byte     = byte_r;
  assign out_byte_index     = bidx_r;
  assign out_last           = last_r;
  assign out_payload_length = plen_r;
  assign out_checksum       = csum_r;
  assign out_status         = status_r;

endmodule

@@ rtl/escaped_frame_receiver.sv @@
`timescale 1ns / 1ps
// Byte-stuffed frame receiver. Raw link bytes are taken one per cycle while the
// block collects a frame, be they data bytes, escapes or start bytes. An end
// byte hands the frame to the sequencer, which reads the two checksum bytes
// from the receive store in states S_CLO, S_CHI and S_CHK, then emits the frame
// bytes before the checksum, header first, each transfer passing through states
// S_FETCH, S_LOAD and S_OUT; a rejected frame (too short or too long) gives a
// single transfer with status set and frame byte zero. These steps follow from
// the single read port of the receive store, whose read data is registered. The
// input is not ready from the end byte until the last transfer of the frame.
// Configuration registers are written through cfg_wr_en, cfg_addr and cfg_wdata
// and should only change while no frame is being emitted.

module escaped_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  output logic [5:0]  out_payload_length,
  output logic [15:0] out_checksum,
  output logic [1:0]  out_status,
  output logic [2:0]  out_channel
);
  import efr_pkg::*;

  cfg_t             cfg_r;
  wr_req_t          wr;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_byte <= 8'd125;
      cfg_r.start_byte  <= 8'd123;
      cfg_r.end_byte    <= 8'd126;
      cfg_r.channel_id  <= 3'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_ESCAPE:  cfg_r.escape_byte <= cfg_wdata;
        CFG_START:   cfg_r.start_byte  <= cfg_wdata;
        CFG_END:     cfg_r.end_byte    <= cfg_wdata;
        CFG_CHANNEL: cfg_r.channel_id  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  efr_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_byte     (out_frame_byte),
    .out_byte_index     (out_byte_index),
    .out_last           (out_last),
    .out_payload_length (out_payload_length),
    .out_checksum       (out_checksum),
    .out_status         (out_status),
    .wr                 (wr),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data)
  );

  efr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_channel = cfg_r.channel_id;

endmodule

@@ rtl/efr_checker.sv @@
`timescale 1ns / 1ps

module efr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_frame_byte,
  input logic [5:0]  out_byte_index,
  input logic        out_last,
  input logic [5:0]  out_payload_length,
  input logic [15:0] out_checksum,
  input logic [1:0]  out_status
);
  import efr_pkg::*;

  // no input taken while a result is on offer
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_byte_index) && $stable(out_checksum))
    else $error("stalled result changed");

  // reject is a single zero transfer
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_byte_index == 6'd0 &&
      out_frame_byte == 8'd0 && out_payload_length == 6'd0)
    else $error("malformed reject result");

  // last transfer returns to collecting
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("frame did not close after last transfer");

  // indices climb by one within a frame
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> ##2
      (out_valid && out_byte_index == $past(out_byte_index, 3) + 6'd1))
    else $error("byte index out of sequence");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);
